### hw/rtl/gx_texel_format_decoder_macros.svh
// Assertion macros shared by the texel format decoder checker.
`ifndef GX_TEXEL_FORMAT_DECODER_MACROS_SVH
`define GX_TEXEL_FORMAT_DECODER_MACROS_SVH

// Same-cycle implication on aclk, disabled in reset.
`define GTFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk, disabled in reset.
`define GTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gtfd_pkg.sv
// Package: format codes, stage payload types and channel expansion helpers.
`timescale 1ns / 1ps
package gtfd_pkg;

    typedef logic [2:0] texfmt_t;

    localparam texfmt_t FMT_I4     = 3'd0;
    localparam texfmt_t FMT_I8     = 3'd1;
    localparam texfmt_t FMT_IA4    = 3'd2;
    localparam texfmt_t FMT_RGB565 = 3'd3;
    localparam texfmt_t FMT_RGB5A3 = 3'd4;
    localparam texfmt_t FMT_RGBA8  = 3'd5;
    localparam texfmt_t FMT_CMPR   = 3'd6;
    localparam texfmt_t FMT_RSVD   = 3'd7;

    localparam texfmt_t FMT_RESET  = FMT_I8;

    localparam logic [3:0] SLOT_LAST_CMPR = 4'd15;

    // One texel to decode, issued by the issue stage.
    typedef struct packed {
        texfmt_t     fmt;
        logic [3:0]  slot;
        logic        last;
        logic [63:0] word;
    } job_t;

    // Fields picked out for one texel.
    typedef struct packed {
        texfmt_t     fmt;
        logic [3:0]  slot;
        logic        last;
        logic [1:0]  code;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [31:0] src;
    } sel_t;

    // One finished texel.
    typedef struct packed {
        logic [3:0] slot;
        logic       last;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } texel_t;

    function automatic logic [7:0] x4(input logic [3:0] n);
        return {n, n};
    endfunction

    function automatic logic [7:0] x5(input logic [4:0] n);
        return {n, n[4:2]};
    endfunction

    function automatic logic [7:0] x6(input logic [5:0] n);
        return {n, n[5:4]};
    endfunction

endpackage

### hw/rtl/gx_texel_format_decoder.sv
// Top level: texel format decoder from packed source units to RGBA8888 texels.
//
// Usage:
//   cfg_valid/cfg_data write texel_format (0 I4, 1 I8, 2 IA4, 3 RGB565,
//   4 RGB5A3, 5 RGBA8, 6 CMPR); cfg_ready is always high. Write it only while
//   no transaction is in flight.
//   s_tvalid/s_tready/s_tdata carry one source unit per transaction, right
//   aligned, first byte most significant.
//   m_tvalid/m_tready/m_tdata/m_tlast carry one texel per transaction; m_tlast
//   marks the final texel of a source unit. Code 7 units are dropped.
// Throughput: one source unit per cycle for I8, IA4, RGB565, RGB5A3 and RGBA8
//   while m_tready is high; an I4 unit yields two texels and a CMPR unit sixteen,
//   stepped by the slot counter of the issue stage, which emits one texel per cycle unless stalled.
// Pipeline: three register stages (issue, field select, expand); a texel passes
//   through them in that order, registered in each, before it shows on m_tvalid.
// Reset: aresetn low clears every stage and sets texel_format to I8.
// Stall: with m_tready low the output texel holds and the stages behind it
//   fill up, then s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module gx_texel_format_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // raw_word[63:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // red[7:0], green[15:8], blue[23:16], alpha[31:24],
                                    // texel_slot[35:32], zero pad[39:36]
    output logic        m_tlast
);
    import gtfd_pkg::*;

    texfmt_t texel_format_reg;
    job_t    job;
    logic    job_valid, job_ready;
    sel_t    sel;
    logic    sel_valid, sel_ready;
    texel_t  texel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            texel_format_reg <= FMT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            texel_format_reg <= cfg_data;
        end
    end

    gtfd_issue u_issue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fmt       (texel_format_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    gtfd_fetch u_fetch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (job_valid),
        .in_ready  (job_ready),
        .job       (job),
        .out_valid (sel_valid),
        .out_ready (sel_ready),
        .sel       (sel)
    );

    gtfd_expand u_expand (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .sel       (sel),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .texel     (texel)
    );

    assign m_tdata = {4'd0, texel.slot, texel.alpha, texel.blue, texel.green, texel.red};
    assign m_tlast = texel.last;

endmodule

### hw/rtl/gtfd_issue.sv
// Issue stage: holds one source unit and steps through its texel slots.
`timescale 1ns / 1ps
module gtfd_issue (
    input  logic              aclk,
    input  logic              aresetn,
    input  gtfd_pkg::texfmt_t fmt,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [63:0]       in_word,
    output logic              job_valid,
    input  logic              job_ready,
    output gtfd_pkg::job_t    job
);
    import gtfd_pkg::*;

    logic        busy_reg, busy_next;
    texfmt_t     fmt_reg, fmt_next;
    logic [3:0]  slot_reg, slot_next;
    logic [63:0] word_reg, word_next;
    logic        job_last;
    logic        job_done;

    always_comb begin
        case (fmt_reg)
            FMT_I4:   job_last = slot_reg[0];
            FMT_CMPR: job_last = (slot_reg == SLOT_LAST_CMPR);
            default:  job_last = 1'b1;
        endcase
    end

    assign job_done  = busy_reg && job_ready && job_last;
    assign in_ready  = !busy_reg || job_done;
    assign job_valid = busy_reg;
    assign job.fmt   = fmt_reg;
    assign job.slot  = slot_reg;
    assign job.last  = job_last;
    assign job.word  = word_reg;

    always_comb begin
        busy_next = busy_reg;
        fmt_next  = fmt_reg;
        slot_next = slot_reg;
        word_next = word_reg;
        if (in_valid && in_ready) begin
            busy_next = (fmt != FMT_RSVD);
            fmt_next  = fmt;
            slot_next = 4'd0;
            word_next = in_word;
        end else if (job_done) begin
            busy_next = 1'b0;
        end else if (busy_reg && job_ready) begin
            slot_next = slot_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        fmt_reg  <= fmt_next;
        slot_reg <= slot_next;
        word_reg <= word_next;
    end

endmodule

### hw/rtl/gtfd_fetch.sv
// Field select stage: picks the nibble, code and endpoints for one texel.
`timescale 1ns / 1ps
module gtfd_fetch (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  gtfd_pkg::job_t job,
    output logic           out_valid,
    input  logic           out_ready,
    output gtfd_pkg::sel_t sel
);
    import gtfd_pkg::*;

    logic       valid_reg;
    sel_t       sel_reg, sel_next;
    logic [3:0] nib;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign sel       = sel_reg;

    always_comb begin
        nib           = job.slot[0] ? job.word[3:0] : job.word[7:4];
        sel_next.fmt  = job.fmt;
        sel_next.slot = job.slot;
        sel_next.last = job.last;
        sel_next.code = job.word[{job.slot, 1'b0} +: 2];
        sel_next.c0   = job.word[63:48];
        sel_next.c1   = job.word[47:32];
        if (job.fmt == FMT_I4) begin
            sel_next.src = {24'd0, nib, nib};
        end else begin
            sel_next.src = job.word[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sel_reg <= sel_next;
        end
    end

endmodule

### hw/rtl/gtfd_expand.sv
// Expand stage: widens channels, blends CMPR endpoints, holds the output texel.
`timescale 1ns / 1ps
module gtfd_expand (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  gtfd_pkg::sel_t   sel,
    output logic             out_valid,
    input  logic             out_ready,
    output gtfd_pkg::texel_t texel
);
    import gtfd_pkg::*;

    logic        valid_reg;
    texel_t      texel_reg, texel_next;
    logic [15:0] h;
    logic [7:0]  r0, g0, b0, r1, g1, b1;
    logic [8:0]  rs, gs, bs;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign texel     = texel_reg;

    always_comb begin
        h  = sel.src[15:0];
        r0 = {sel.c0[15:11], 3'd0};
        g0 = {sel.c0[10:5], 2'd0};
        b0 = {sel.c0[4:0], 3'd0};
        r1 = {sel.c1[15:11], 3'd0};
        g1 = {sel.c1[10:5], 2'd0};
        b1 = {sel.c1[4:0], 3'd0};
        rs = {1'b0, r0} + {1'b0, r1};
        gs = {1'b0, g0} + {1'b0, g1};
        bs = {1'b0, b0} + {1'b0, b1};

        texel_next.slot  = sel.slot;
        texel_next.last  = sel.last;
        texel_next.red   = 8'h00;
        texel_next.green = 8'h00;
        texel_next.blue  = 8'h00;
        texel_next.alpha = 8'hFF;
        case (sel.fmt)
            FMT_I4, FMT_I8: begin
                texel_next.red   = sel.src[7:0];
                texel_next.green = sel.src[7:0];
                texel_next.blue  = sel.src[7:0];
            end
            FMT_IA4: begin
                texel_next.red   = x4(sel.src[7:4]);
                texel_next.green = x4(sel.src[7:4]);
                texel_next.blue  = x4(sel.src[7:4]);
                texel_next.alpha = x4(sel.src[3:0]);
            end
            FMT_RGB565: begin
                texel_next.red   = x5(h[15:11]);
                texel_next.green = x6(h[10:5]);
                texel_next.blue  = x5(h[4:0]);
            end
            FMT_RGB5A3: begin
                if (h[15]) begin
                    texel_next.red   = x5(h[14:10]);
                    texel_next.green = x5(h[9:5]);
                    texel_next.blue  = x5(h[4:0]);
                end else begin
                    texel_next.red   = x4(h[11:8]);
                    texel_next.green = x4(h[7:4]);
                    texel_next.blue  = x4(h[3:0]);
                    texel_next.alpha = {h[14:12], h[14:12], h[14:13]};
                end
            end
            FMT_RGBA8: begin
                texel_next.red   = sel.src[31:24];
                texel_next.green = sel.src[23:16];
                texel_next.blue  = sel.src[15:8];
                texel_next.alpha = sel.src[7:0];
            end
            FMT_CMPR: begin
                case (sel.code)
                    2'd0: begin
                        texel_next.red   = r0;
                        texel_next.green = g0;
                        texel_next.blue  = b0;
                    end
                    2'd1: begin
                        texel_next.red   = r1;
                        texel_next.green = g1;
                        texel_next.blue  = b1;
                    end
                    default: begin
                        texel_next.red   = rs[8:1];
                        texel_next.green = gs[8:1];
                        texel_next.blue  = bs[8:1];
                        texel_next.alpha = sel.code[0] ? 8'h00 : 8'hFF;
                    end
                endcase
            end
            default: begin
                texel_next.alpha = 8'h00;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            texel_reg <= texel_next;
        end
    end

endmodule

### hw/rtl/gtfd_checker.sv
// Port checker for the texel format decoder, bound to the top level.
`timescale 1ns / 1ps
`include "gx_texel_format_decoder_macros.svh"
module gtfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    import gtfd_pkg::*;

    logic       first_reg;
    logic [3:0] slot_reg;
    logic [3:0] slot;

    assign slot = m_tdata[35:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            first_reg <= m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            slot_reg <= slot;
        end
    end

    `GTFD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output texel changed under stall")
    `GTFD_ASSERT_NOW(a_last_slot, m_tvalid && !m_tlast, slot != SLOT_LAST_CMPR, "slot 15 without last")
    `GTFD_ASSERT_NOW(a_first_slot, m_tvalid && first_reg, slot == 4'd0, "first texel not in slot 0")
    `GTFD_ASSERT_NOW(a_slot_step, m_tvalid && !first_reg, slot == slot_reg + 4'd1, "texel slot skipped")

endmodule

bind gx_texel_format_decoder gtfd_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for gx_texel_format_decoder: every texel format, random stalls.

import gtfd_pkg::*;

typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] slot;
    logic       last;
} texel_exp_t;

class texel_scoreboard;
    texfmt_t    fmt;
    texel_exp_t expected_texels[$];
    int         mismatches;

    function new();
        fmt = FMT_RESET;
        mismatches = 0;
    endfunction

    function void set_format(texfmt_t f);
        fmt = f;
    endfunction

    function int pending();
        return expected_texels.size();
    endfunction

    function logic [7:0] widen4(logic [3:0] n);
        logic [7:0] v;
        v = {4'h0, n};
        return (v << 4) | v;
    endfunction

    function logic [7:0] widen5(logic [4:0] n);
        logic [7:0] v;
        v = {3'h0, n};
        return (v << 3) | (v >> 2);
    endfunction

    function logic [7:0] widen6(logic [5:0] n);
        logic [7:0] v;
        v = {2'h0, n};
        return (v << 2) | (v >> 4);
    endfunction

    function void push(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                       logic [3:0] slot, logic last);
        texel_exp_t t;
        t.red   = r;
        t.green = g;
        t.blue  = b;
        t.alpha = a;
        t.slot  = slot;
        t.last  = last;
        expected_texels.insert(expected_texels.size(), t);
    endfunction

    function void note_unit(logic [63:0] w);
        logic [7:0]  b8;
        logic [15:0] h;
        logic [7:0]  iv;
        logic [2:0]  a3;
        logic [7:0]  av;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [7:0]  r0, g0, bl0, r1, g1, bl1;
        logic [8:0]  sr, sg, sb;
        logic [1:0]  code;
        b8 = w[7:0];
        h  = w[15:0];
        case (fmt)
            FMT_I4: begin
                iv = widen4(b8[7:4]);
                push(iv, iv, iv, 8'hFF, 4'd0, 1'b0);
                iv = widen4(b8[3:0]);
                push(iv, iv, iv, 8'hFF, 4'd1, 1'b1);
            end
            FMT_I8: push(b8, b8, b8, 8'hFF, 4'd0, 1'b1);
            FMT_IA4: begin
                iv = widen4(b8[7:4]);
                push(iv, iv, iv, widen4(b8[3:0]), 4'd0, 1'b1);
            end
            FMT_RGB565:
                push(widen5(h[15:11]), widen6(h[10:5]), widen5(h[4:0]), 8'hFF, 4'd0, 1'b1);
            FMT_RGB5A3: begin
                if (h[15]) begin
                    push(widen5(h[14:10]), widen5(h[9:5]), widen5(h[4:0]), 8'hFF, 4'd0, 1'b1);
                end else begin
                    a3 = h[14:12];
                    av = {a3, 5'b0} | {3'b0, a3, 2'b0} | {6'b0, a3[2:1]};
                    push(widen4(h[11:8]), widen4(h[7:4]), widen4(h[3:0]), av, 4'd0, 1'b1);
                end
            end
            FMT_RGBA8: push(w[31:24], w[23:16], w[15:8], w[7:0], 4'd0, 1'b1);
            FMT_CMPR: begin
                c0  = w[63:48];
                c1  = w[47:32];
                r0  = {c0[15:11], 3'b0};
                g0  = {c0[10:5], 2'b0};
                bl0 = {c0[4:0], 3'b0};
                r1  = {c1[15:11], 3'b0};
                g1  = {c1[10:5], 2'b0};
                bl1 = {c1[4:0], 3'b0};
                sr  = {1'b0, r0} + {1'b0, r1};
                sg  = {1'b0, g0} + {1'b0, g1};
                sb  = {1'b0, bl0} + {1'b0, bl1};
                for (int k = 0; k < 16; k++) begin
                    code = w[2*k +: 2];
                    case (code)
                        2'd0: push(r0, g0, bl0, 8'hFF, k[3:0], k == 15);
                        2'd1: push(r1, g1, bl1, 8'hFF, k[3:0], k == 15);
                        2'd2: push(sr[8:1], sg[8:1], sb[8:1], 8'hFF, k[3:0], k == 15);
                        default: push(sr[8:1], sg[8:1], sb[8:1], 8'h00, k[3:0], k == 15);
                    endcase
                end
            end
            default: ;
        endcase
    endfunction

    function string show(texel_exp_t t);
        return $sformatf("r=%h g=%h b=%h a=%h slot=%0d last=%0d",
                         t.red, t.green, t.blue, t.alpha, t.slot, t.last);
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s", $time, msg);
    endfunction

    function void check_texel(logic [39:0] data, logic last);
        texel_exp_t got;
        texel_exp_t want;
        got.red   = data[7:0];
        got.green = data[15:8];
        got.blue  = data[23:16];
        got.alpha = data[31:24];
        got.slot  = data[35:32];
        got.last  = last;
        if (expected_texels.size() == 0) begin
            flag({"unexpected texel: ", show(got)});
        end else begin
            want = expected_texels.pop_front();
            if (got !== want)
                flag({"texel mismatch: expected ", show(want), ", got ", show(got)});
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int DRAIN_CYCLES = 8;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // raw_word[63:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // red[7:0], green[15:8], blue[23:16], alpha[31:24],
                             // texel_slot[35:32], zero pad[39:36]
    logic        m_tlast;

    texel_scoreboard sb = new();
    int calm_left[2];

    gx_texel_format_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left[side] = $urandom_range(8, 40);
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_unit(input logic [63:0] word);
        int gap;
        gap = draw_wait(0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_unit(word);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic change_format(input texfmt_t f);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= f;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_format(f);
    endtask

    // Texel sink with random backpressure
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait(1);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_texel(m_tdata, m_tlast);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL gx_texel_format_decoder");
        $finish;
    end

    initial begin
        texfmt_t f;
        int n;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= FMT_I8;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Run on the reset format first
        send_unit(64'hFFFF_FFFF_FFFF_FF00);
        send_unit(64'h0000_0000_0000_00FF);
        change_format(FMT_I4);
        send_unit(64'h0000_0000_0000_00A5);
        send_unit(64'hFFFF_FFFF_FFFF_FFF0);
        change_format(FMT_IA4);
        send_unit(64'h0000_0000_0000_000F);
        send_unit(64'hFFFF_FFFF_FFFF_FFF0);
        change_format(FMT_RGB565);
        send_unit(64'h0000_0000_0000_FFFF);
        send_unit(64'hFFFF_FFFF_FFFF_0000);
        send_unit(64'h0000_0000_0000_F81F);
        change_format(FMT_RGB5A3);
        send_unit(64'h0000_0000_0000_8000);
        send_unit(64'h0000_0000_0000_FFFF);
        send_unit(64'hFFFF_FFFF_FFFF_7FFF);
        send_unit(64'h0000_0000_0000_0000);
        send_unit(64'h0000_0000_0000_5A5A);
        change_format(FMT_RGBA8);
        send_unit(64'hFFFF_FFFF_1234_5678);
        send_unit(64'h0000_0000_FFFF_FFFF);
        change_format(FMT_CMPR);
        send_unit(64'hFFFF_0000_E4E4_E4E4);
        send_unit(64'h0000_FFFF_FFFF_FFFF);
        send_unit(64'hF81F_07E0_1B1B_1B1B);
        change_format(FMT_RSVD);
        send_unit(64'hFFFF_FFFF_FFFF_FFFF);
        send_unit(64'h0000_0000_0000_0000);

        for (int p = 0; p < 11; p++) begin
            f = (p < 8) ? texfmt_t'(p) : texfmt_t'($urandom_range(0, 7));
            n = (f == FMT_RSVD) ? 4 : 10;
            change_format(f);
            repeat (n) send_unit(random_word());
        end

        wait_idle();
        if (sb.mismatches == 0)
            $display("PASS gx_texel_format_decoder");
        else
            $display("FAIL gx_texel_format_decoder");
        $finish;
    end
endmodule
